// File: src/zid_pkg.sv
`timescale 1ns / 1ps

package zid_pkg;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  form;
        logic [5:0]  opcode_number;
        logic [3:0]  operand_count;
        logic [15:0] operand_types;
        logic [2:0]  header_bytes;
        logic        illegal;
        logic        is_halt;
        logic        is_call;
    } t_out_word;

    localparam logic [2:0] FORM_LONG  = 3'd0;
    localparam logic [2:0] FORM_SHORT = 3'd1;
    localparam logic [2:0] FORM_ZERO  = 3'd2;
    localparam logic [2:0] FORM_VAR   = 3'd3;
    localparam logic [2:0] FORM_EXT   = 3'd4;

    localparam logic [3:0] VERSION_RESET = 4'd3;
    localparam logic [3:0] VERSION_EXT_MIN_EXCL = 4'd4;

    localparam logic [0:0] REG_VERSION = 1'b0;

endpackage

// File: src/zcode_instruction_decoder.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload              Handshake
// in        input      t_in_word (4 bytes)  i_in_valid / o_in_stall
// out       output     t_out_word           o_out_valid / i_out_stall
// config    input      version register     APB psel/penable/pwrite, paddr[2] = 0
//
// A word is registered on input, decoded combinationally and registered on output;
// one word per cycle is sustained while the output does not stall.
// Reset is synchronous and active low; it empties both stages and sets version to 3.
// A stall on the output holds the result register; the input register keeps
// accepting until it holds a word that cannot move on.

module zcode_instruction_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  zid_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output zid_pkg::t_out_word  o_out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic               r_in_valid;
    logic               n_in_valid;
    zid_pkg::t_in_word  r_in_word;
    zid_pkg::t_in_word  n_in_word;
    logic               r_out_valid;
    logic               n_out_valid;
    zid_pkg::t_out_word r_out_word;
    zid_pkg::t_out_word n_out_word;
    zid_pkg::t_out_word dec_word;
    logic [3:0]         version;
    logic               move_out;
    logic               in_ready;

    zid_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_version (version)
    );

    zid_decode u_decode (
        .i_version (version),
        .i_word    (r_in_word),
        .o_word    (dec_word)
    );

    assign move_out = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_ready = !r_in_valid || move_out;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in_word   = r_in_word;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (move_out) begin
            n_out_valid = 1'b1;
            n_out_word  = dec_word;
            n_in_valid  = 1'b0;
        end
        if (in_ready && i_in_valid) begin
            n_in_valid = 1'b1;
            n_in_word  = i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_word  <= n_in_word;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: src/zid_apb_regs.sv
`timescale 1ns / 1ps

module zid_apb_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [3:0]  o_version
);

    logic [3:0] r_version;
    logic [3:0] n_version;
    logic       sel_version;

    assign sel_version = (paddr[2] == zid_pkg::REG_VERSION);
    assign pready      = 1'b1;

    always_comb begin
        n_version = r_version;
        if (psel && penable && pwrite && sel_version) begin
            n_version = pwdata[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= zid_pkg::VERSION_RESET;
        end else begin
            r_version <= n_version;
        end
    end

    assign prdata    = sel_version ? {28'd0, r_version} : 32'd0;
    assign o_version = r_version;

endmodule

// File: src/zid_decode.sv
`timescale 1ns / 1ps

module zid_decode (
    input  logic [3:0]         i_version,
    input  zid_pkg::t_in_word  i_word,
    output zid_pkg::t_out_word o_word
);

    typedef struct packed {
        logic [3:0]  count;
        logic [15:0] types;
    } t_scan;

    // Type pairs are read from the most significant pair down; the first
    // omitted pair ends loading and every later slot reads as omitted.
    function automatic t_scan scan_spec(input logic [15:0] spec);
        t_scan      res;
        logic       stop;
        logic [1:0] ty;
        res.count = 4'd0;
        res.types = 16'hFFFF;
        stop      = 1'b0;
        for (int k = 0; k < 8; k++) begin
            ty = spec[15 - 2 * k -: 2];
            if (!stop && ty != 2'b11) begin
                res.types[2 * k +: 2] = ty;
                res.count = res.count + 4'd1;
            end else begin
                stop = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic twoop_var_legal(input logic [5:0] op);
        logic legal;
        unique case (op) inside
            6'h00, 6'h1d, 6'h1e, 6'h1f, 6'h30: legal = 1'b0;
            default: legal = 1'b1;
        endcase
        return legal;
    endfunction

    function automatic logic twoop_var_call(input logic [5:0] op);
        logic callf;
        unique case (op) inside
            6'h19, 6'h1a, 6'h20, 6'h2c, 6'h39, 6'h3a: callf = 1'b1;
            default: callf = 1'b0;
        endcase
        return callf;
    endfunction

    function automatic logic ext_legal(input logic [5:0] op);
        logic legal;
        unique case (op) inside
            6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h09, 6'h0a: legal = 1'b1;
            default: legal = 1'b0;
        endcase
        return legal;
    endfunction

    function automatic logic two_byte_spec(input logic [5:0] op);
        return (op == 6'h2c) || (op == 6'h3a);
    endfunction

    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       ext_en;
    logic [5:0] ext_op;
    logic [5:0] var_op;
    logic [3:0] low_op;
    t_scan      ext_scan;
    t_scan      var_scan;

    assign b0     = i_word.byte0;
    assign b1     = i_word.byte1;
    assign b2     = i_word.byte2;
    assign b3     = i_word.byte3;
    assign ext_en = i_version > zid_pkg::VERSION_EXT_MIN_EXCL;
    assign ext_op = b1[5:0];
    assign var_op = b0[5:0];
    assign low_op = b0[3:0];

    assign ext_scan = two_byte_spec(ext_op) ? scan_spec({b2, b3}) : scan_spec({b2, 8'hFF});
    assign var_scan = two_byte_spec(var_op) ? scan_spec({b1, b2}) : scan_spec({b1, 8'hFF});

    always_comb begin
        o_word               = '0;
        o_word.operand_types = 16'hFFFF;
        o_word.header_bytes  = 3'd1;
        if (ext_en && b0 == 8'hBE) begin
            o_word.form          = zid_pkg::FORM_EXT;
            o_word.opcode_number = ext_op;
            o_word.operand_count = ext_scan.count;
            o_word.operand_types = ext_scan.types;
            o_word.header_bytes  = two_byte_spec(ext_op) ? 3'd4 : 3'd3;
            o_word.illegal       = !ext_legal(ext_op);
        end else if (!b0[7]) begin
            o_word.form          = zid_pkg::FORM_LONG;
            o_word.opcode_number = {1'b0, b0[4:0]};
            o_word.operand_count = 4'd2;
            o_word.operand_types = {12'hFFF, (b0[5] ? 2'd2 : 2'd1), (b0[6] ? 2'd2 : 2'd1)};
            o_word.illegal       = !twoop_var_legal({1'b0, b0[4:0]});
            o_word.is_call       = twoop_var_call({1'b0, b0[4:0]});
        end else if (b0[6]) begin
            o_word.form          = zid_pkg::FORM_VAR;
            o_word.opcode_number = var_op;
            o_word.operand_count = var_scan.count;
            o_word.operand_types = var_scan.types;
            o_word.header_bytes  = two_byte_spec(var_op) ? 3'd3 : 3'd2;
            o_word.illegal       = !twoop_var_legal(var_op);
            o_word.is_call       = twoop_var_call(var_op);
        end else if (b0[5:4] != 2'b11) begin
            o_word.form          = zid_pkg::FORM_SHORT;
            o_word.opcode_number = {2'b00, low_op};
            o_word.operand_count = 4'd1;
            o_word.operand_types = {14'h3FFF, b0[5:4]};
            o_word.is_call       = (low_op == 4'h8) || (low_op == 4'hF && ext_en);
        end else begin
            o_word.form          = zid_pkg::FORM_ZERO;
            o_word.opcode_number = {2'b00, low_op};
            o_word.illegal       = (low_op == 4'h4) || (low_op == 4'hE);
            o_word.is_halt       = (low_op == 4'hA);
        end
    end

endmodule

// File: src/zid_checker.sv
`timescale 1ns / 1ps

module zid_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input zid_pkg::t_out_word o_out_word
);

    // A stalled result word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // An accepted word passes the input register, then the output register, and reaches the output when nothing stalls.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall ##1 !i_out_stall ##1 !i_out_stall |-> o_out_valid)
        else $error("accepted word did not reach the output");

    a_long_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.form == zid_pkg::FORM_LONG |->
            o_out_word.operand_count == 4'd2 && o_out_word.header_bytes == 3'd1)
        else $error("long form with wrong count or header length");

    a_halt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.is_halt |->
            o_out_word.form == zid_pkg::FORM_ZERO && !o_out_word.is_call)
        else $error("halt flagged outside zero-operand form");

endmodule

bind zcode_instruction_decoder zid_checker u_zid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam logic [7:0] EXT_PREFIX       = 8'hbe;
    localparam logic [5:0] OP_CALL_VS2      = 6'h2c;
    localparam logic [5:0] OP_CALL_VN2      = 6'h3a;
    localparam logic [5:0] OP_CALL_2S       = 6'h19;
    localparam logic [5:0] OP_CALL_2N       = 6'h1a;
    localparam logic [5:0] OP_CALL_VS       = 6'h20;
    localparam logic [5:0] OP_CALL_VN       = 6'h39;
    localparam logic [5:0] OP_NONE_LOW      = 6'h00;
    localparam logic [5:0] OP_NONE_1D       = 6'h1d;
    localparam logic [5:0] OP_NONE_1E       = 6'h1e;
    localparam logic [5:0] OP_NONE_1F       = 6'h1f;
    localparam logic [5:0] OP_NONE_30       = 6'h30;
    localparam logic [5:0] EXT_SET_FONT     = 6'h04;
    localparam logic [5:0] EXT_SAVE_UNDO    = 6'h09;
    localparam logic [5:0] EXT_RESTORE_UNDO = 6'h0a;
    localparam logic [3:0] SHORT_CALL_1S    = 4'h8;
    localparam logic [3:0] SHORT_CALL_1N    = 4'hf;
    localparam logic [3:0] ZOP_UNUSED       = 4'h4;
    localparam logic [3:0] ZOP_QUIT         = 4'ha;
    localparam logic [3:0] ZOP_EXTENDED     = 4'he;
    localparam logic [1:0] TY_SMALL         = 2'd1;
    localparam logic [1:0] TY_VAR           = 2'd2;
    localparam logic [1:0] TY_NONE          = 2'd3;
    localparam logic [2:0] ADDR_VERSION     = {zid_pkg::REG_VERSION, 2'b00};
    localparam int         N_PHASES         = 10;
    localparam int         RANDOM_PER_PHASE = 132;
    localparam int         QUIET_LIMIT      = 2000;

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_stall;
    zid_pkg::t_in_word  in_word = '0;
    logic               o_out_valid;
    logic               out_stall = 1'b0;
    zid_pkg::t_out_word o_out_word;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    zid_pkg::t_in_word  windows_pending[$];
    zid_pkg::t_out_word decodes_due[$];
    logic [3:0]         ver_cfg = zid_pkg::VERSION_RESET;
    logic               tx_idle = 1'b1;
    logic               rx_idle = 1'b1;
    int                 n_in = 0;
    int                 n_out = 0;
    int                 n_err = 0;
    int                 tx_gap = 0;
    int                 rx_wait = 0;
    int                 quiet = 0;
    logic [31:0] ver_writes [N_PHASES] = '{32'd0, 32'd5, 32'd4, 32'd1, 32'd8, 32'd0,
                                           32'hdeadbeef, 32'd9, 32'd6, 32'd2};

    zcode_instruction_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Specifier pairs are read from the most significant end; loading stops at
    // the first omitted type and every later slot reads as omitted.
    function automatic void scan_types(input logic [15:0] spec, input int slots,
                                       output logic [3:0] cnt, output logic [15:0] types);
        logic       stopped;
        logic [1:0] ty;
        int         k;
        cnt = '0;
        types = 16'hffff;
        stopped = 1'b0;
        for (k = 0; k < slots; k++) begin
            ty = spec[2 * (slots - 1 - k) +: 2];
            if (!stopped && ty != TY_NONE) begin
                types[2 * k +: 2] = ty;
                cnt++;
            end else begin
                stopped = 1'b1;
            end
        end
    endfunction

    function automatic logic twoop_legal(input logic [5:0] op);
        return !(op == OP_NONE_LOW || op == OP_NONE_1D || op == OP_NONE_1E ||
                 op == OP_NONE_1F || op == OP_NONE_30);
    endfunction

    function automatic logic twoop_call(input logic [5:0] op);
        return op == OP_CALL_2S || op == OP_CALL_2N || op == OP_CALL_VS ||
               op == OP_CALL_VN || op == OP_CALL_VS2 || op == OP_CALL_VN2;
    endfunction

    function automatic zid_pkg::t_out_word decode_instr(input zid_pkg::t_in_word w,
                                                        input logic [3:0] ver);
        zid_pkg::t_out_word r;
        logic [3:0]         cnt;
        logic [15:0]        ty;
        logic [5:0]         op;
        r = '0;
        r.operand_types = 16'hffff;
        r.header_bytes = 3'd1;
        if (ver > zid_pkg::VERSION_EXT_MIN_EXCL && w.byte0 == EXT_PREFIX) begin
            op = w.byte1[5:0];
            r.form = zid_pkg::FORM_EXT;
            if (op == OP_CALL_VS2 || op == OP_CALL_VN2) begin
                scan_types({w.byte2, w.byte3}, 8, cnt, ty);
                r.header_bytes = 3'd4;
            end else begin
                scan_types({8'h00, w.byte2}, 4, cnt, ty);
                r.header_bytes = 3'd3;
            end
            r.operand_count = cnt;
            r.operand_types = ty;
            r.illegal = !(op <= EXT_SET_FONT || op == EXT_SAVE_UNDO || op == EXT_RESTORE_UNDO);
        end else if (!w.byte0[7]) begin
            op = {1'b0, w.byte0[4:0]};
            r.form = zid_pkg::FORM_LONG;
            r.operand_count = 4'd2;
            r.operand_types = {12'hfff, w.byte0[5] ? TY_VAR : TY_SMALL,
                               w.byte0[6] ? TY_VAR : TY_SMALL};
            r.illegal = !twoop_legal(op);
            r.is_call = twoop_call(op);
        end else if (w.byte0[6]) begin
            op = w.byte0[5:0];
            r.form = zid_pkg::FORM_VAR;
            if (op == OP_CALL_VS2 || op == OP_CALL_VN2) begin
                scan_types({w.byte1, w.byte2}, 8, cnt, ty);
                r.header_bytes = 3'd3;
            end else begin
                scan_types({8'h00, w.byte1}, 4, cnt, ty);
                r.header_bytes = 3'd2;
            end
            r.operand_count = cnt;
            r.operand_types = ty;
            r.illegal = !twoop_legal(op);
            r.is_call = twoop_call(op);
        end else if (w.byte0[5:4] != TY_NONE) begin
            op = {2'b00, w.byte0[3:0]};
            r.form = zid_pkg::FORM_SHORT;
            r.operand_count = 4'd1;
            r.operand_types = {14'h3fff, w.byte0[5:4]};
            r.is_call = op[3:0] == SHORT_CALL_1S ||
                        (op[3:0] == SHORT_CALL_1N && ver > zid_pkg::VERSION_EXT_MIN_EXCL);
        end else begin
            op = {2'b00, w.byte0[3:0]};
            r.form = zid_pkg::FORM_ZERO;
            r.illegal = op[3:0] == ZOP_UNUSED || op[3:0] == ZOP_EXTENDED;
            r.is_halt = op[3:0] == ZOP_QUIT;
        end
        r.opcode_number = op;
        return r;
    endfunction

    function automatic int field_bad(input string name, input logic [15:0] want,
                                     input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic zid_pkg::t_in_word rand_window();
        zid_pkg::t_in_word w;
        w = zid_pkg::t_in_word'($urandom);
        case ($urandom_range(0, 9))
            0, 1: w.byte0 = EXT_PREFIX;
            2: w.byte0 = {2'b11, $urandom_range(0, 1) ? OP_CALL_VS2 : OP_CALL_VN2};
            3: w.byte0 = {2'b11, 6'($urandom)};
            default: ;
        endcase
        if (w.byte0 == EXT_PREFIX && $urandom_range(0, 2) == 0) begin
            w.byte1 = {2'($urandom), $urandom_range(0, 1) ? OP_CALL_VS2 : OP_CALL_VN2};
        end
        if ($urandom_range(0, 4) == 0) begin
            w.byte1 = $urandom_range(0, 1) ? 8'h00 : 8'hff;
        end
        return w;
    endfunction

    task automatic queue_window(input logic [7:0] b0, input logic [7:0] b1,
                                input logic [7:0] b2, input logic [7:0] b3);
        windows_pending.push_back({b0, b1, b2, b3});
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (windows_pending.size() != 0 || in_valid || decodes_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end else if (!(in_valid && o_in_stall)) begin
            if (in_valid) begin
                decodes_due.push_back(decode_instr(in_word, ver_cfg));
                n_in++;
            end
            if (tx_gap > 0) begin
                tx_gap--;
                in_valid <= 1'b0;
            end else if (windows_pending.size() != 0) begin
                in_word <= windows_pending.pop_front();
                in_valid <= 1'b1;
                tx_gap = tx_idle ? $urandom_range(0, 5) : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Twice in the run the output is held off long enough to back up the
    // pipeline while the driver keeps offering words.
    always @(posedge i_clk) begin
        zid_pkg::t_out_word due;
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                n_out++;
                if (decodes_due.size() == 0) begin
                    $error("result 0x%0h arrived with nothing expected", o_out_word);
                    n_err++;
                end else begin
                    due = decodes_due.pop_front();
                    if (field_bad("form", 16'(due.form), 16'(o_out_word.form)) +
                        field_bad("opcode_number", 16'(due.opcode_number),
                                  16'(o_out_word.opcode_number)) +
                        field_bad("operand_count", 16'(due.operand_count),
                                  16'(o_out_word.operand_count)) +
                        field_bad("operand_types", due.operand_types,
                                  o_out_word.operand_types) +
                        field_bad("header_bytes", 16'(due.header_bytes),
                                  16'(o_out_word.header_bytes)) +
                        field_bad("illegal", 16'(due.illegal), 16'(o_out_word.illegal)) +
                        field_bad("is_halt", 16'(due.is_halt), 16'(o_out_word.is_halt)) +
                        field_bad("is_call", 16'(due.is_call), 16'(o_out_word.is_call)) != 0)
                    begin
                        n_err++;
                    end
                end
                rx_wait = rx_idle ? $urandom_range(0, 5) : 0;
                if (n_out == 300 || n_out == 900) begin
                    rx_wait = 80;
                end
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            out_stall <= (rx_wait > 0);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int ph;
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                apb_write(ADDR_VERSION, ver_writes[ph]);
                ver_cfg = ver_writes[ph][3:0];
            end
            @(negedge i_clk);
            tx_idle = (ph == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_idle = (ph == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (ph == 0) begin
                queue_window(8'h00, 8'h00, 8'h00, 8'h00);
                queue_window(8'h7f, 8'hff, 8'hff, 8'hff);
                queue_window(8'h19, 8'h12, 8'h34, 8'h56);
                queue_window(8'h5a, 8'h00, 8'h00, 8'h00);
                queue_window(8'h80, 8'h00, 8'h00, 8'h00);
                queue_window(8'haf, 8'hff, 8'h00, 8'hff);
                queue_window(8'h98, 8'h00, 8'h00, 8'h00);
                queue_window(8'hb0, 8'h00, 8'h00, 8'h00);
                queue_window(8'hb4, 8'h00, 8'h00, 8'h00);
                queue_window(8'hba, 8'h00, 8'h00, 8'h00);
                queue_window(8'hbe, 8'h00, 8'h00, 8'h00);
                queue_window(8'hbf, 8'hff, 8'hff, 8'hff);
                queue_window(8'hc0, 8'h1b, 8'h00, 8'h00);
                queue_window(8'hec, 8'h00, 8'h00, 8'h00);
                queue_window(8'hfa, 8'h55, 8'h57, 8'h00);
                queue_window(8'he0, 8'hff, 8'h00, 8'h00);
                queue_window(8'hf0, 8'he4, 8'h00, 8'h00);
                queue_window(8'hff, 8'h00, 8'hff, 8'hff);
            end else if (ph == 1) begin
                queue_window(8'hbe, 8'h00, 8'h00, 8'h00);
                queue_window(8'hbe, 8'h04, 8'h1b, 8'h00);
                queue_window(8'hbe, 8'hca, 8'hff, 8'h00);
                queue_window(8'hbe, 8'h05, 8'h00, 8'h00);
                queue_window(8'hbe, 8'h2c, 8'h55, 8'h57);
                queue_window(8'hbe, 8'hff, 8'he4, 8'h00);
                queue_window(8'hbe, 8'h3a, 8'hff, 8'h00);
                queue_window(8'h8f, 8'h00, 8'h00, 8'h00);
            end
            repeat (RANDOM_PER_PHASE) windows_pending.push_back(rand_window());
        end
        wait_drained();
        $display("Decoded %0d instruction windows under %0d version settings,", n_in, N_PHASES);
        $display("covering every form, extended prefixes and long output stalls.");
        if (n_err == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
